@@ design/all_pkg.sv @@
// Shared constants and types for the array linked list.
package all_pkg;
  localparam int NodeCount = 64;
  localparam int IdxW = $clog2(NodeCount + 1);
  localparam int AddrW = $clog2(NodeCount);
  localparam int CntW = IdxW;
  localparam logic [IdxW-1:0] NullLink = IdxW'(NodeCount);

  localparam logic [1:0] KindIns = 2'd0;
  localparam logic [1:0] KindDel = 2'd1;
  localparam logic [1:0] KindRd = 2'd2;
  localparam logic [1:0] KindRsv = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StRange = 2'd3;

  typedef struct packed {
    logic load;      // capture request, reset walk
    logic scan_step; // advance free scan
    logic walk_step; // follow one link
    logic commit;    // apply update and form result
    logic relink;    // second link write of an insert
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic walk_done;
    logic reject;    // early status decided
  } stat_t;
endpackage

@@ design/array_linked_list.sv @@
// Top level of the array linked list.
// One request at a time; in_ready_o is high only while idle. After the input
// transfer the request is loaded, the free scan steps to the lowest free node
// (or to the end when every node is taken), the walk follows position links,
// then commit and relink run and the result is offered; every kind runs the free
// scan, and a rejected request passes through scan and walk without stepping. The
// result is held until taken; the next request can transfer in the cycle after.
module array_linked_list import all_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [6:0]  position_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] read_value_o,
  output logic [6:0]  length_o,
  output logic        empty_res_o
);
  cmd_t cmd;
  stat_t stat;

  all_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o,
    .out_ready_i, .stat_i(stat), .cmd_o(cmd));

  all_datapath u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .kind_i,
    .position_i, .value_i, .status_o, .read_value_o, .length_o, .empty_res_o);
endmodule

@@ design/all_datapath.sv @@
// Datapath: node stores, free scan, link walk, result register.
module all_datapath import all_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output stat_t           stat_o,
  input  logic [1:0]      kind_i,
  input  logic [6:0]      position_i,
  input  logic [31:0]     value_i,
  output logic [1:0]      status_o,
  output logic [31:0]     read_value_o,
  output logic [6:0]      length_o,
  output logic            empty_res_o
);
  logic [31:0]     node_value [NodeCount];
  logic [IdxW-1:0] node_link [NodeCount];
  logic [NodeCount-1:0] free_q;
  logic [IdxW-1:0] head_q;
  logic [CntW-1:0] count_q;
  logic [1:0]      kind_q;
  logic [6:0]      pos_q;
  logic [31:0]     val_q;
  logic [IdxW-1:0] scan_q, cur_q, cur_d, prev_q, link_rd_q;
  logic [6:0]      steps_q;
  logic            found_q;
  logic            link_pend_q;
  logic            link_we;
  logic [AddrW-1:0] link_wa;
  logic [IdxW-1:0] link_wd;

  logic [1:0] early;
  logic       has_early;
  always_comb begin
    has_early = 1'b1;
    early = StRange;
    case (kind_q)
      KindIns: begin
        if (count_q >= CntW'(NodeCount)) early = StFull;
        else if (7'(pos_q) > 7'(count_q)) early = StRange;
        else has_early = 1'b0;
      end
      KindDel, KindRd: begin
        if (count_q == '0) early = StEmpty;
        else if (7'(pos_q) >= 7'(count_q)) early = StRange;
        else has_early = 1'b0;
      end
      default: early = StRange;
    endcase
  end

  // walk pos links: cur ends on the node at pos, prev on its predecessor
  assign stat_o.reject = has_early;
  assign stat_o.scan_done = found_q || (scan_q == NullLink);
  assign stat_o.walk_done = (steps_q == pos_q);

  logic [AddrW-1:0] ca, fa, pa;
  assign ca = cur_q[AddrW-1:0];
  assign fa = scan_q[AddrW-1:0];
  assign pa = prev_q[AddrW-1:0];

  // link_rd_q always holds the link of cur_q
  always_comb begin
    cur_d = cur_q;
    if (cmd_i.load) cur_d = head_q;
    else if (cmd_i.walk_step) cur_d = link_rd_q;
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = fa;
    link_wd = cur_q;
    if (cmd_i.commit && !has_early) begin
      if (kind_q == KindIns) begin
        link_we = 1'b1;
      end else if (kind_q == KindDel && pos_q != 7'd0) begin
        link_we = 1'b1;
        link_wa = pa;
        link_wd = link_rd_q;
      end
    end else if (cmd_i.relink && link_pend_q) begin
      link_we = 1'b1;
      link_wa = pa;
      link_wd = scan_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) node_link[link_wa] <= link_wd;
    link_rd_q <= node_link[cur_d[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
      head_q <= NullLink;
      count_q <= '0;
      kind_q <= '0;
      pos_q <= '0;
      val_q <= '0;
      found_q <= 1'b0;
      scan_q <= '0;
      cur_q <= NullLink;
      prev_q <= NullLink;
      steps_q <= '0;
      link_pend_q <= 1'b0;
      status_o <= StOk;
      read_value_o <= '0;
    end else begin
      cur_q <= cur_d;
      if (cmd_i.load) begin
        kind_q <= kind_i;
        pos_q <= position_i;
        val_q <= value_i;
        scan_q <= '0;
        found_q <= 1'b0;
        prev_q <= NullLink;
        steps_q <= '0;
        link_pend_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        if (free_q[fa]) found_q <= 1'b1;
        else scan_q <= scan_q + IdxW'(1);
      end
      if (cmd_i.walk_step) begin
        prev_q <= cur_q;
        steps_q <= steps_q + 7'd1;
      end
      if (cmd_i.commit) begin
        status_o <= has_early ? early : StOk;
        read_value_o <= (!has_early && kind_q == KindRd) ? node_value[ca] : '0;
        link_pend_q <= !has_early && kind_q == KindIns && pos_q != 7'd0;
        if (!has_early) begin
          case (kind_q)
            KindIns: begin
              if (pos_q == 7'd0) head_q <= scan_q;
              free_q[fa] <= 1'b0;
              count_q <= count_q + CntW'(1);
            end
            KindDel: begin
              if (pos_q == 7'd0) head_q <= link_rd_q;
              free_q[ca] <= 1'b1;
              count_q <= count_q - CntW'(1);
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !has_early && kind_q == KindIns) node_value[fa] <= val_q;
  end

  // length/empty reflect count after commit
  assign length_o = 7'(count_q);
  assign empty_res_o = (count_q == '0);
endmodule

@@ design/all_ctrl.sv @@
// Controller: sequences scan, walk and commit for one request.
module all_ctrl import all_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  localparam logic [2:0] SIdle = 3'd0, SScan = 3'd1, SWalk = 3'd2,
                         SCommit = 3'd3, SOut = 3'd4, SLink = 3'd5;
  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = SScan;
        end
      end
      SScan: begin
        if (stat_i.reject || stat_i.scan_done) state_d = SWalk;
        else cmd_o.scan_step = 1'b1;
      end
      SWalk: begin
        if (stat_i.reject || stat_i.walk_done) state_d = SCommit;
        else cmd_o.walk_step = 1'b1;
      end
      SCommit: begin
        cmd_o.commit = 1'b1;
        state_d = SLink;
      end
      SLink: begin
        cmd_o.relink = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("multiple commands");
  a_commit_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> cmd_o.relink) else $error("commit without relink");
  a_link_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.relink |=> out_valid_o) else $error("relink without result");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !out_valid_o) else $error("load while result pending");
`endif
endmodule
